>>> sv/lidar_nearest_obstacle_tracker_core_macros.svh
// Assertion helpers used by the tracker core module
`ifndef LIDAR_NEAREST_OBSTACLE_TRACKER_CORE_MACROS_SVH
`define LIDAR_NEAREST_OBSTACLE_TRACKER_CORE_MACROS_SVH

// Check that an implication holds on every clock edge outside reset
`define LNOT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an implication holds in the cycle after its antecedent
`define LNOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lnot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lnot_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int TIMER_BITS_DEF     = 20;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // Input item kinds
    localparam logic [1:0] KIND_POSE   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Report kinds
    localparam logic [1:0] REP_EMERGENCY  = 2'd0;
    localparam logic [1:0] REP_MOVED      = 2'd1;
    localparam logic [1:0] REP_STATIONARY = 2'd2;
    localparam logic [1:0] REP_REFRESH    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMERG     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STATION   = 3'd7;

    // Sine polynomial coefficients, Q30
    localparam logic [31:0] COEF_A = 32'd1686629713;
    localparam logic [31:0] COEF_B = 32'd688904866;
    localparam logic [31:0] COEF_C = 32'd76016977;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

endpackage
`default_nettype wire

>>> sv/lidar_nearest_obstacle_tracker_core.sv
// Nearest-obstacle tracker. Takes pose, lidar sample and tick beats on one
// valid/ready channel and gives up to two report beats per input on the other.
// Pose beats, unused kinds and samples that need no work leave the sequencer
// in idle; a tick passes through the emit state, which loads a refresh report
// when one is due. A usable sample runs its cosine, sine and scaling through
// one shared shift-add multiplier that retires one bit per cycle; each product
// has a start step, one shift step per multiplier bit and a result step, and
// each axis takes five products. Closing a scan against a known enemy adds two
// more products for the distance test. Any item that leaves a report is also
// held while the report side stalls. Only one item is in flight at a time; the
// output register lets the next beat be accepted while the last report still
// waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "lidar_nearest_obstacle_tracker_core_macros.svh"
module lidar_nearest_obstacle_tracker_core #(
    parameter int ANGLE_BITS     = lnot_pkg::ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = lnot_pkg::TRIG_FRAC_BITS_DEF,
    parameter int TIMER_BITS     = lnot_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      kind,
    input  wire logic signed [15:0]              pose_x,
    input  wire logic signed [15:0]              pose_y,
    input  wire logic [15:0]                     pose_heading,
    input  wire logic [15:0]                     sample_range,
    input  wire logic                            sample_valid,
    input  wire logic [15:0]                     sample_angle,
    input  wire logic                            scan_end,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           report_kind,
    output logic [13:0]                          report_x,
    output logic [13:0]                          report_y,
    output logic                                 last_of_run,
    input  wire logic                            cfg_we,
    input  wire logic [lnot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lnot_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lnot_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_Z2, S_Z2W, S_P1, S_P1W, S_P2, S_P2W, S_ZP, S_ZPW,
        S_SCALE, S_SCALEW, S_BOUNDS, S_CLOSE, S_DX, S_DXW, S_DY, S_DYW,
        S_JUDGE, S_EMIT
    } state_t;

    localparam logic [TIMER_BITS-1:0] TMAX  = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);
    localparam int CMP_W = (TIMER_BITS > 20) ? TIMER_BITS : 20;
    localparam int SH = 30 - TRIG_FRAC_BITS;
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic [31:0] S_HALF = 32'd1 << (SH - 1);
    localparam logic [63:0] V_HALF = 64'd1 << (TRIG_FRAC_BITS - 1);
    localparam logic [31:0] ANGLE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    // Configuration registers
    logic [13:0] x_limit_reg, y_limit_reg;
    logic [15:0] min_range_reg, max_range_reg, emerg_reg, refresh_reg;
    logic [11:0] move_thr_reg;
    logic [19:0] station_reg;

    // Tracking state
    logic signed [15:0] robot_x_reg, robot_y_reg;
    logic [15:0] heading_reg;
    logic pose_known_reg, have_best_reg, scan_stopped_reg, enemy_known_reg;
    logic [15:0] best_range_reg;
    logic [13:0] best_x_reg, best_y_reg, enemy_x_reg, enemy_y_reg;
    logic [TIMER_BITS-1:0] tick_rep_reg, tick_move_reg;

    // Sample datapath
    state_t state_reg;
    logic [15:0] r_reg;
    logic        last_reg, axis_reg;
    logic [31:0] t_reg;
    logic [31:0] z_reg, z2_reg, p_reg;
    logic [TRIG_FRAC_BITS:0] trig_mag_reg;
    logic        trig_neg_reg;
    logic signed [17:0] gx_reg, gy_reg;
    logic [29:0] d2_reg;

    // Pending report beats of the current item
    logic [1:0]  q_kind_reg [2];
    logic [13:0] q_x_reg [2];
    logic [13:0] q_y_reg [2];
    logic [1:0]  q_cnt_reg, emit_idx_reg;

    // Output register
    logic [1:0]  rep_kind_reg;
    logic [13:0] rep_x_reg, rep_y_reg;
    logic        rep_last_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    lnot_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    logic [31:0] t_cur;
    logic [31:0] f_cur, z_cur;
    logic [31:0] prod_hi;
    logic [31:0] s_round;
    logic [63:0] v_round;
    logic signed [17:0] base_sel, mag_s, g_new;
    logic        inb;
    logic [13:0] dx_abs, dy_abs;
    logic [23:0] thr2;
    logic        move_big;
    logic [TIMER_BITS-1:0] tick_rep_inc, tick_move_inc;
    logic        refresh_hit, station_hit;
    logic        out_load;

    // Select the turn angle for the axis under work; cosine is sine a quarter later
    always_comb
    begin
        t_cur = axis_reg ? t_reg : (t_reg + Q30_ONE);
        f_cur = {2'b00, t_cur[29:0]};
        z_cur = t_cur[30] ? (Q30_ONE - f_cur) : f_cur;
        prod_hi = mrsp.p[61:30];
        s_round = prod_hi + S_HALF;
        v_round = mrsp.p + V_HALF;
        base_sel = axis_reg ? {{2{robot_y_reg[15]}}, robot_y_reg}
                            : {{2{robot_x_reg[15]}}, robot_x_reg};
        mag_s = {1'b0, v_round[TRIG_FRAC_BITS +: 17]};
        g_new = trig_neg_reg ? (base_sel - mag_s) : (base_sel + mag_s);
        inb = (gx_reg >= 18'sd0) && (gx_reg <= $signed({4'd0, x_limit_reg}))
              && (gy_reg >= 18'sd0) && (gy_reg <= $signed({4'd0, y_limit_reg}));
        dx_abs = (best_x_reg >= enemy_x_reg) ? (best_x_reg - enemy_x_reg)
                                             : (enemy_x_reg - best_x_reg);
        dy_abs = (best_y_reg >= enemy_y_reg) ? (best_y_reg - enemy_y_reg)
                                             : (enemy_y_reg - best_y_reg);
        thr2 = {12'd0, move_thr_reg} * {12'd0, move_thr_reg};
        move_big = d2_reg > {6'd0, thr2};
        tick_rep_inc = (tick_rep_reg != TMAX) ? (tick_rep_reg + T_ONE) : tick_rep_reg;
        tick_move_inc = (tick_move_reg != TMAX) ? (tick_move_reg + T_ONE) : tick_move_reg;
        refresh_hit = CMP_W'(tick_rep_inc) >= CMP_W'(refresh_reg);
        station_hit = CMP_W'(tick_move_reg) > CMP_W'(station_reg);
        out_load = (state_reg == S_EMIT) && (emit_idx_reg != q_cnt_reg)
                   && (!out_valid || out_ready);
    end

    // Drive the multiplier requests from the sequencer
    always_comb
    begin
        mreq.start = 1'b0;
        mreq.a = '0;
        mreq.b = '0;
        unique case (state_reg)
            S_Z2:
            begin
                mreq.start = 1'b1; mreq.a = z_cur; mreq.b = z_cur;
            end
            S_P1:
            begin
                mreq.start = 1'b1; mreq.a = z2_reg; mreq.b = COEF_C;
            end
            S_P2:
            begin
                mreq.start = 1'b1; mreq.a = z2_reg; mreq.b = p_reg;
            end
            S_ZP:
            begin
                mreq.start = 1'b1; mreq.a = z_reg; mreq.b = p_reg;
            end
            S_SCALE:
            begin
                mreq.start = 1'b1; mreq.a = {16'd0, r_reg};
                mreq.b = 32'(trig_mag_reg);
            end
            S_DX:
            begin
                mreq.start = 1'b1; mreq.a = {18'd0, dx_abs}; mreq.b = {18'd0, dx_abs};
            end
            S_DY:
            begin
                mreq.start = 1'b1; mreq.a = {18'd0, dy_abs}; mreq.b = {18'd0, dy_abs};
            end
            default: ;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_limit_reg <= 14'd2950; y_limit_reg <= 14'd1950;
            min_range_reg <= 16'd166; max_range_reg <= 16'd12000;
            emerg_reg <= 16'd100; move_thr_reg <= 12'd50;
            refresh_reg <= 16'd1000; station_reg <= 20'd10000;
            robot_x_reg <= '0; robot_y_reg <= '0; heading_reg <= '0;
            pose_known_reg <= 1'b0; have_best_reg <= 1'b0;
            scan_stopped_reg <= 1'b0; enemy_known_reg <= 1'b0;
            best_range_reg <= 16'hFFFF; best_x_reg <= '0; best_y_reg <= '0;
            enemy_x_reg <= '0; enemy_y_reg <= '0;
            tick_rep_reg <= '0; tick_move_reg <= '0;
            r_reg <= '0; last_reg <= 1'b0; axis_reg <= 1'b0; t_reg <= '0;
            z_reg <= '0; z2_reg <= '0; p_reg <= '0;
            trig_mag_reg <= '0; trig_neg_reg <= 1'b0;
            gx_reg <= '0; gy_reg <= '0; d2_reg <= '0;
            q_kind_reg[0] <= '0; q_kind_reg[1] <= '0;
            q_x_reg[0] <= '0; q_x_reg[1] <= '0;
            q_y_reg[0] <= '0; q_y_reg[1] <= '0;
            q_cnt_reg <= '0; emit_idx_reg <= '0;
            out_valid <= 1'b0;
            rep_kind_reg <= '0; rep_x_reg <= '0; rep_y_reg <= '0; rep_last_reg <= 1'b0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_X_LIMIT:   x_limit_reg   <= cfg_data[13:0];
                    REG_Y_LIMIT:   y_limit_reg   <= cfg_data[13:0];
                    REG_MIN_RANGE: min_range_reg <= cfg_data[15:0];
                    REG_MAX_RANGE: max_range_reg <= cfg_data[15:0];
                    REG_EMERG:     emerg_reg     <= cfg_data[15:0];
                    REG_MOVE_THR:  move_thr_reg  <= cfg_data[11:0];
                    REG_REFRESH:   refresh_reg   <= cfg_data[15:0];
                    REG_STATION:   station_reg   <= cfg_data[19:0];
                    default: ;
                endcase
            end

            // Load the next report beat, or drain the output register
            if (out_load)
            begin
                out_valid <= 1'b1;
                rep_kind_reg <= q_kind_reg[emit_idx_reg[0]];
                rep_x_reg <= q_x_reg[emit_idx_reg[0]];
                rep_y_reg <= q_y_reg[emit_idx_reg[0]];
                rep_last_reg <= ((emit_idx_reg + 2'd1) == q_cnt_reg);
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (kind)
                            KIND_POSE:
                            begin
                                robot_x_reg <= pose_x; robot_y_reg <= pose_y;
                                heading_reg <= pose_heading; pose_known_reg <= 1'b1;
                            end
                            KIND_SAMPLE:
                            begin
                                r_reg <= sample_range; last_reg <= scan_end;
                                t_reg <= {heading_reg + sample_angle, 16'd0} & ANGLE_KEEP;
                                axis_reg <= 1'b0;
                                if (scan_stopped_reg)
                                begin
                                    if (scan_end) scan_stopped_reg <= 1'b0;
                                end
                                else if (pose_known_reg && sample_valid
                                         && sample_range >= min_range_reg
                                         && sample_range <= max_range_reg)
                                begin
                                    state_reg <= S_Z2;
                                end
                                else if (scan_end)
                                begin
                                    state_reg <= S_CLOSE;
                                end
                            end
                            KIND_TICK:
                            begin
                                tick_move_reg <= tick_move_inc;
                                if (enemy_known_reg && refresh_hit)
                                begin
                                    tick_rep_reg <= '0;
                                    q_kind_reg[q_cnt_reg[0]] <= REP_REFRESH;
                                    q_x_reg[q_cnt_reg[0]] <= enemy_x_reg;
                                    q_y_reg[q_cnt_reg[0]] <= enemy_y_reg;
                                    q_cnt_reg <= q_cnt_reg + 2'd1;
                                end
                                else
                                begin
                                    tick_rep_reg <= tick_rep_inc;
                                end
                                state_reg <= S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_Z2:
                begin
                    z_reg <= z_cur;
                    trig_neg_reg <= t_cur[31];
                    state_reg <= S_Z2W;
                end
                S_Z2W:
                begin
                    if (mrsp.done)
                    begin
                        z2_reg <= prod_hi;
                        state_reg <= S_P1;
                    end
                end
                S_P1: state_reg <= S_P1W;
                S_P1W:
                begin
                    if (mrsp.done)
                    begin
                        p_reg <= COEF_B - prod_hi;
                        state_reg <= S_P2;
                    end
                end
                S_P2: state_reg <= S_P2W;
                S_P2W:
                begin
                    if (mrsp.done)
                    begin
                        p_reg <= COEF_A - prod_hi;
                        state_reg <= S_ZP;
                    end
                end
                S_ZP: state_reg <= S_ZPW;
                S_ZPW:
                begin
                    // round the Q30 sine to the trig fraction width
                    if (mrsp.done)
                    begin
                        trig_mag_reg <= s_round[SH +: TRIG_FRAC_BITS + 1];
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: state_reg <= S_SCALEW;
                S_SCALEW:
                begin
                    // x first, then rerun the chain for y
                    if (mrsp.done)
                    begin
                        if (!axis_reg)
                        begin
                            gx_reg <= g_new;
                            axis_reg <= 1'b1;
                            state_reg <= S_Z2;
                        end
                        else
                        begin
                            gy_reg <= g_new;
                            state_reg <= S_BOUNDS;
                        end
                    end
                end
                S_BOUNDS:
                begin
                    if (r_reg < emerg_reg)
                    begin
                        // emergency ends the scan here, reported only when on the table
                        if (inb)
                        begin
                            q_kind_reg[q_cnt_reg[0]] <= REP_EMERGENCY;
                            q_x_reg[q_cnt_reg[0]] <= gx_reg[13:0];
                            q_y_reg[q_cnt_reg[0]] <= gy_reg[13:0];
                            q_cnt_reg <= q_cnt_reg + 2'd1;
                        end
                        scan_stopped_reg <= !last_reg;
                        state_reg <= S_CLOSE;
                    end
                    else
                    begin
                        if (inb && (!have_best_reg || r_reg < best_range_reg))
                        begin
                            have_best_reg <= 1'b1;
                            best_range_reg <= r_reg;
                            best_x_reg <= gx_reg[13:0];
                            best_y_reg <= gy_reg[13:0];
                        end
                        state_reg <= last_reg ? S_CLOSE : S_EMIT;
                    end
                end
                S_CLOSE:
                begin
                    if (!have_best_reg)
                    begin
                        best_range_reg <= 16'hFFFF;
                        best_x_reg <= '0; best_y_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (!enemy_known_reg)
                    begin
                        state_reg <= S_JUDGE;
                    end
                    else
                    begin
                        state_reg <= S_DX;
                    end
                end
                S_DX: state_reg <= S_DXW;
                S_DXW:
                begin
                    if (mrsp.done)
                    begin
                        d2_reg <= {2'b00, mrsp.p[27:0]};
                        state_reg <= S_DY;
                    end
                end
                S_DY: state_reg <= S_DYW;
                S_DYW:
                begin
                    if (mrsp.done)
                    begin
                        d2_reg <= d2_reg + {2'b00, mrsp.p[27:0]};
                        state_reg <= S_JUDGE;
                    end
                end
                S_JUDGE:
                begin
                    // publish a new or moved enemy, else repeat a long-stationary one
                    if (!enemy_known_reg || move_big)
                    begin
                        enemy_known_reg <= 1'b1;
                        enemy_x_reg <= best_x_reg; enemy_y_reg <= best_y_reg;
                        tick_rep_reg <= '0; tick_move_reg <= '0;
                        q_kind_reg[q_cnt_reg[0]] <= REP_MOVED;
                        q_x_reg[q_cnt_reg[0]] <= best_x_reg;
                        q_y_reg[q_cnt_reg[0]] <= best_y_reg;
                        q_cnt_reg <= q_cnt_reg + 2'd1;
                    end
                    else if (station_hit)
                    begin
                        tick_move_reg <= '0;
                        q_kind_reg[q_cnt_reg[0]] <= REP_STATIONARY;
                        q_x_reg[q_cnt_reg[0]] <= enemy_x_reg;
                        q_y_reg[q_cnt_reg[0]] <= enemy_y_reg;
                        q_cnt_reg <= q_cnt_reg + 2'd1;
                    end
                    have_best_reg <= 1'b0;
                    best_range_reg <= 16'hFFFF;
                    best_x_reg <= '0; best_y_reg <= '0;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // hand pending beats to the output register one at a time
                    if (emit_idx_reg == q_cnt_reg)
                    begin
                        q_cnt_reg <= '0;
                        emit_idx_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (out_load)
                    begin
                        emit_idx_reg <= emit_idx_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign report_kind = rep_kind_reg;
    assign report_x    = rep_x_reg;
    assign report_y    = rep_y_reg;
    assign last_of_run = rep_last_reg;

    `LNOT_ASSERT_IMPL(a_no_accept_busy, state_reg != S_IDLE, !in_ready, "accept while busy")
    `LNOT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(report_kind) && $stable(report_x) && $stable(report_y) && $stable(last_of_run), "report beat changed while waiting")
    `LNOT_ASSERT_NEXT(a_timer_sat, tick_move_reg == TMAX, tick_move_reg == TMAX || tick_move_reg == '0, "timer wrap")
    `LNOT_ASSERT_IMPL(a_best_reset, !have_best_reg, best_range_reg == 16'hFFFF, "best range not cleared")
endmodule
`default_nettype wire

>>> sv/lnot_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module lnot_serial_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lnot_pkg::mul_req_t req,
    output lnot_pkg::mul_rsp_t     rsp
);
    import lnot_pkg::*;

    // Shift-add multiplier, one bit of b per cycle
    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            a_next    = {32'd0, req.a};
            b_next    = req.b;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add the shifted multiplicand when the current multiplier bit is set
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[62:0], 1'b0};
            b_next   = {1'b0, b_reg[31:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;
endmodule
`default_nettype wire
